### hdl/tvfs_pkg.sv
// ----------------------------------------------------------------------------
// tvfs_pkg
// shared constants and helpers of the trilinear vector field sampler
// ----------------------------------------------------------------------------
package tvfs_pkg;

  // grid shape and fraction precision
  localparam int COUNT_X       = 16;
  localparam int COUNT_Y       = 16;
  localparam int COUNT_Z       = 16;
  localparam int FRACTION_BITS = 16;

  // fixed field widths
  localparam int COORD_W   = 32;
  localparam int FIELD_W   = 32;
  localparam int ADDR_W    = 12;
  localparam int DEPTH     = 4096;
  localparam int ENTRY_W   = 3 * FIELD_W;
  localparam int CFG_IDX_W = 3;

  // last valid configuration register index
  localparam logic [CFG_IDX_W-1:0] LAST_REG = 3'd5;

  // item codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // derived widths
  localparam int MAX_XY    = (COUNT_X > COUNT_Y) ? COUNT_X : COUNT_Y;
  localparam int MAX_COUNT = (MAX_XY > COUNT_Z) ? MAX_XY : COUNT_Z;
  localparam int IDX_W     = (MAX_COUNT <= 2) ? 1 : $clog2(MAX_COUNT);
  localparam int QW        = IDX_W + FRACTION_BITS;
  localparam int STEP_W    = $clog2(QW);
  localparam int W_W       = FRACTION_BITS + 1;
  localparam int MA_W      = COORD_W + 2;
  localparam int MB_W      = FRACTION_BITS + 2;
  localparam int P_W       = MA_W + MB_W;
  localparam int ACC_W     = P_W;

  // sample count minus one along an axis
  function automatic logic [IDX_W-1:0] count_m1(logic [1:0] axis);
    logic [IDX_W-1:0] r;
    case (axis)
      AXIS_X:  r = IDX_W'(COUNT_X - 1);
      AXIS_Y:  r = IDX_W'(COUNT_Y - 1);
      AXIS_Z:  r = IDX_W'(COUNT_Z - 1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hdl/tvfs_in_if.sv
// ----------------------------------------------------------------------------
// tvfs_in_if
// input channel: sample writes and point queries
// ----------------------------------------------------------------------------
interface tvfs_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [11:0] sample_index;
  logic [31:0] write_bx;
  logic [31:0] write_by;
  logic [31:0] write_bz;
  logic [31:0] query_x;
  logic [31:0] query_y;
  logic [31:0] query_z;

  modport source (
    output valid, op, sample_index, write_bx, write_by, write_bz,
           query_x, query_y, query_z,
    input  ready
  );
  modport sink (
    input  valid, op, sample_index, write_bx, write_by, write_bz,
           query_x, query_y, query_z,
    output ready
  );
endinterface

### hdl/tvfs_out_if.sv
// ----------------------------------------------------------------------------
// tvfs_out_if
// result channel: interpolated field per query
// ----------------------------------------------------------------------------
interface tvfs_out_if;
  logic        valid;
  logic        ready;
  logic        inside_res;
  logic [31:0] out_bx;
  logic [31:0] out_by;
  logic [31:0] out_bz;

  modport source (
    output valid, inside_res, out_bx, out_by, out_bz,
    input  ready
  );
  modport sink (
    input  valid, inside_res, out_bx, out_by, out_bz,
    output ready
  );
endinterface

### hdl/tvfs_ram.sv
// ----------------------------------------------------------------------------
// tvfs_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tvfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/trilinear_vector_field_sampler.sv
// ----------------------------------------------------------------------------
// trilinear_vector_field_sampler
// samples a stored 3-d vector field at a point by trilinear weighting
// ----------------------------------------------------------------------------
// A write beat (op 0) stores one Bx/By/Bz sample at a flat index and gives
// no result. A query beat (op 1) gives one result beat. Per axis a query
// runs the range check and the offset multiply and then, unless the axis
// has a single sample or a zero span, loads the divider and runs a
// one-bit-per-cycle restoring divider that yields the QW = IDX_W +
// FRACTION_BITS bits of cell and fraction together. Then each of the eight
// corners forms its weight product and, when its weight is nonzero, runs
// the three multiply-accumulates, all on one shared 34x18 multiplier; a
// last step rounds and hands off the result. A point outside the bounds
// returns early. The block takes no new beat while a query is in flight;
// a finished result sits in the output register and the next beat is
// accepted while it waits. Bounds are to be written over the cfg port
// only while the block is idle; the block itself does not enforce this.
// Store entries hold garbage until written.
// ----------------------------------------------------------------------------
module trilinear_vector_field_sampler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [tvfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tvfs_pkg::COORD_W-1:0]   cfg_wdata,
  tvfs_in_if.sink                        in_chan,
  tvfs_out_if.source                     out_chan
);
  import tvfs_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_AXIS  = 9'b000000010,
    S_DLOAD = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_W1    = 9'b000010000,
    S_W2    = 9'b000100000,
    S_WT    = 9'b001000000,
    S_MAC   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  localparam logic [W_W-1:0] ONE_W = {1'b1, {FRACTION_BITS{1'b0}}};

  state_t state;

  // bound registers, low/high pairs per axis
  logic [COORD_W-1:0] bnd [6];

  // latched query point
  logic [COORD_W-1:0] qpt [3];

  // per axis location
  logic [IDX_W-1:0] cell_idx [3];
  logic [W_W-1:0]   frac [3];

  // sequencer counters
  logic [1:0]        axis;
  logic [STEP_W-1:0] step;
  logic [2:0]        corner;
  logic [1:0]        comp;

  // divider
  logic [COORD_W-1:0] span_r;
  logic [COORD_W-1:0] rem;
  logic [QW-1:0]      sh;
  logic [QW-1:0]      quo;
  logic [COORD_W:0]   div_t;
  logic [COORD_W:0]   div_diff;
  logic               div_ge;
  logic [QW-1:0]      quo_next;
  logic [IDX_W-1:0]   qcell;

  // shared multiplier
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [P_W-1:0]  product;
  logic signed [P_W-1:0]  prod_r;
  logic [W_W-1:0]         weight_r;
  logic [W_W-1:0]         wsh;

  // accumulators and result
  logic signed [ACC_W-1:0] acc [3];
  logic                    inside_r;
  logic                    out_valid;
  logic                    out_inside;
  logic [FIELD_W-1:0]      out_f [3];

  // axis view
  logic signed [COORD_W-1:0] q_s, lo_s, hi_s;
  logic signed [COORD_W:0]   d_s, sp_s;
  logic [IDX_W-1:0]          m1;
  logic                      outside;

  // corner view
  logic [W_W-1:0]    wc [3];
  logic [IDX_W-1:0]  atc [3];
  logic              skipc;
  logic [31:0]       flat_full;

  // ram
  logic                 ram_we;
  logic                 ram_re;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [FIELD_W-1:0]   samp;

  logic accept;

  assign accept       = in_chan.valid & in_chan.ready;
  assign in_chan.ready = (state == S_IDLE);

  assign out_chan.valid      = out_valid;
  assign out_chan.inside_res = out_inside;
  assign out_chan.out_bx     = out_f[0];
  assign out_chan.out_by     = out_f[1];
  assign out_chan.out_bz     = out_f[2];

  // round half up to whole units, then saturate to 32 bits
  function automatic logic [FIELD_W-1:0] round_sat(logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0]              t;
    logic [ACC_W-FRACTION_BITS:0]       r;
    logic                               fits;
    t = {a[ACC_W-1], a} + (ACC_W+1)'(1 << (FRACTION_BITS - 1));
    r = t[ACC_W:FRACTION_BITS];
    fits = (&r[ACC_W-FRACTION_BITS:FIELD_W-1]) | ~(|r[ACC_W-FRACTION_BITS:FIELD_W-1]);
    if (fits) begin
      return r[FIELD_W-1:0];
    end
    return r[ACC_W-FRACTION_BITS] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  // axis range check and offsets
  always_comb begin
    q_s     = $signed(qpt[axis]);
    lo_s    = $signed(bnd[{axis, 1'b0}]);
    hi_s    = $signed(bnd[{axis, 1'b1}]);
    d_s     = {q_s[COORD_W-1], q_s} - {lo_s[COORD_W-1], lo_s};
    sp_s    = {hi_s[COORD_W-1], hi_s} - {lo_s[COORD_W-1], lo_s};
    m1      = count_m1(axis);
    outside = (q_s < lo_s) || (q_s > hi_s);
  end

  // restoring divider step
  always_comb begin
    div_t    = {rem, sh[QW-1]};
    div_ge   = (div_t >= {1'b0, span_r});
    div_diff = div_t - {1'b0, span_r};
    quo_next = {quo[QW-2:0], div_ge};
    qcell    = quo_next[QW-1:FRACTION_BITS];
  end

  // corner weights and store address
  always_comb begin
    skipc = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (count_m1(2'(a)) == '0) begin
        wc[a]  = ONE_W;
        atc[a] = '0;
        skipc  = skipc | corner[a];
      end else begin
        wc[a]  = corner[a] ? frac[a] : (ONE_W - frac[a]);
        atc[a] = cell_idx[a] + IDX_W'(corner[a]);
      end
    end
    flat_full = (32'(atc[0]) * 32'(COUNT_Y) + 32'(atc[1])) * 32'(COUNT_Z)
                + 32'(atc[2]);
  end

  // sample component for the current accumulate
  always_comb begin
    case (comp)
      2'd0:    samp = ram_rdata[FIELD_W-1:0];
      2'd1:    samp = ram_rdata[2*FIELD_W-1:FIELD_W];
      default: samp = ram_rdata[3*FIELD_W-1:2*FIELD_W];
    endcase
  end

  assign wsh = prod_r[FRACTION_BITS+W_W-1:FRACTION_BITS];

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_AXIS: begin
        ma = MA_W'(d_s);
        mb = MB_W'(m1);
      end
      S_W1: begin
        ma = MA_W'(wc[0]);
        mb = MB_W'(wc[1]);
      end
      S_W2: begin
        ma = MA_W'(wsh);
        mb = MB_W'(wc[2]);
      end
      S_MAC: begin
        ma = MA_W'($signed(samp));
        mb = MB_W'(weight_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign product = ma * mb;

  assign ram_we = accept && (in_chan.op == OP_WRITE);
  assign ram_re = (state == S_W1);

  tvfs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_chan.sample_index),
    .wdata ({in_chan.write_bz, in_chan.write_by, in_chan.write_bx}),
    .re    (ram_re),
    .raddr (flat_full[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // bound registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        bnd[i] <= (i % 2 == 1) ? 32'h0001_0000 : 32'h0000_0000;
      end
    end else if (cfg_wr_en && (cfg_index <= LAST_REG)) begin
      bnd[cfg_index] <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // result beat leaves unless a new one is loaded in this cycle
      if (out_valid && out_chan.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && (in_chan.op == OP_QUERY)) begin
            qpt[0]   <= in_chan.query_x;
            qpt[1]   <= in_chan.query_y;
            qpt[2]   <= in_chan.query_z;
            axis     <= AXIS_X;
            inside_r <= 1'b1;
            for (int c = 0; c < 3; c++) begin
              acc[c] <= '0;
            end
            state    <= S_AXIS;
          end
        end

        S_AXIS: begin
          if (m1 != '0 && outside) begin
            // point off the grid on a sampled axis
            inside_r <= 1'b0;
            state    <= S_FIN;
          end else if (m1 == '0 || sp_s == '0) begin
            // single sample or zero span: cell 0, fraction 0
            cell_idx[axis] <= '0;
            frac[axis]     <= '0;
            if (axis == AXIS_Z) begin
              corner <= '0;
              state  <= S_W1;
            end else begin
              axis   <= axis + 2'd1;
            end
          end else begin
            span_r <= sp_s[COORD_W-1:0];
            prod_r <= product;
            state  <= S_DLOAD;
          end
        end

        S_DLOAD: begin
          // top part of offset*(n-1) is already below span
          rem   <= prod_r[IDX_W+COORD_W-1:IDX_W];
          sh    <= {prod_r[IDX_W-1:0], {FRACTION_BITS{1'b0}}};
          quo   <= '0;
          step  <= '0;
          state <= S_DIV;
        end

        S_DIV: begin
          rem  <= div_ge ? div_diff[COORD_W-1:0] : div_t[COORD_W-1:0];
          sh   <= {sh[QW-2:0], 1'b0};
          quo  <= quo_next;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(QW - 1)) begin
            // far face folds into the last cell with full fraction
            if (qcell >= m1) begin
              cell_idx[axis] <= m1 - IDX_W'(1);
              frac[axis]     <= ONE_W;
            end else begin
              cell_idx[axis] <= qcell;
              frac[axis]     <= {1'b0, quo_next[FRACTION_BITS-1:0]};
            end
            if (axis == AXIS_Z) begin
              corner <= '0;
              state  <= S_W1;
            end else begin
              axis   <= axis + 2'd1;
              state  <= S_AXIS;
            end
          end
        end

        S_W1: begin
          prod_r <= product;
          state  <= S_W2;
        end

        S_W2: begin
          prod_r <= product;
          state  <= S_WT;
        end

        S_WT: begin
          weight_r <= wsh;
          if (skipc || wsh == '0) begin
            if (corner == 3'd7) begin
              state  <= S_FIN;
            end else begin
              corner <= corner + 3'd1;
              state  <= S_W1;
            end
          end else begin
            comp  <= '0;
            state <= S_MAC;
          end
        end

        S_MAC: begin
          // product of one component lands while the previous one is added
          if (comp != 2'd3) begin
            prod_r <= product;
          end
          if (comp != 2'd0) begin
            acc[comp - 2'd1] <= acc[comp - 2'd1] + prod_r;
          end
          comp <= comp + 2'd1;
          if (comp == 2'd3) begin
            if (corner == 3'd7) begin
              state  <= S_FIN;
            end else begin
              corner <= corner + 3'd1;
              state  <= S_W1;
            end
          end
        end

        S_FIN: begin
          if (!out_valid || out_chan.ready) begin
            out_valid  <= 1'b1;
            out_inside <= inside_r;
            for (int c = 0; c < 3; c++) begin
              out_f[c] <= inside_r ? round_sat(acc[c]) : '0;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // divider remainder never reaches the span
  a_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < span_r))
    else $error("divider remainder not below span");

  // a query beat starts the axis walk
  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && in_chan.op == OP_QUERY) |=> (state == S_AXIS))
    else $error("query beat did not start the sequencer");

  // outside results carry zero field
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_inside) |->
      (out_f[0] == '0 && out_f[1] == '0 && out_f[2] == '0))
    else $error("outside result with nonzero field");
`endif

endmodule
